/* hdl/nds_pkg.sv */
`default_nettype none
package nds_pkg;

    localparam int DOME_POINTS     = 1024;
    localparam int COORD_FRAC_BITS = 14;

    localparam int ADDR_W  = $clog2(DOME_POINTS);
    localparam int COUNT_W = $clog2(DOME_POINTS + 1);
    localparam int COORD_W = 16;
    localparam int SIN_W   = COORD_FRAC_BITS + 1;     // 0 .. 2^F
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int ANG_W   = 10;                      // angle + 90, below 720

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;

    // register index codes
    localparam logic REG_POINTS_IN_USE = 1'b0;

    typedef logic [SIN_W-1:0] t_sin_tab [0:90];

    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } t_fold;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_dir_vec;

    // sin(d deg) for d in 0..90: Q2.30 Taylor series, rounded to F fraction bits
    function automatic logic [63:0] sin_first_quadrant(input int d);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        u;
        x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x + HALF_Q30) >> 30;
        term = x;
        acc  = $signed(x);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd6;
        acc  = acc - $signed(term);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd20;
        acc  = acc + $signed(term);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd42;
        acc  = acc - $signed(term);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd72;
        acc  = acc + $signed(term);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd110;
        acc  = acc - $signed(term);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd156;
        acc  = acc + $signed(term);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd210;
        acc  = acc - $signed(term);
        term = ((term * x2 + HALF_Q30) >> 30) / 64'd272;
        acc  = acc + $signed(term);
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > ONE_Q30) begin
            acc = ONE_Q30;
        end
        u = acc;
        if (COORD_FRAC_BITS < 30) begin
            u = (u + (64'd1 << (29 - COORD_FRAC_BITS))) >> (30 - COORD_FRAC_BITS);
        end
        return u;
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab    t;
        logic [63:0] v;
        for (int d = 0; d <= 90; d++) begin
            v    = sin_first_quadrant(d);
            t[d] = v[SIN_W-1:0];
        end
        return t;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

    // reduce an angle below 720 modulo 360 and fold into the first quadrant
    function automatic t_fold fold_angle(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0] r;
        logic [ANG_W-1:0] i;
        t_fold            f;
        r = (a >= ANG_W'(360)) ? a - ANG_W'(360) : a;
        if (r <= ANG_W'(90)) begin
            i     = r;
            f.neg = 1'b0;
        end else if (r <= ANG_W'(180)) begin
            i     = ANG_W'(180) - r;
            f.neg = 1'b0;
        end else if (r <= ANG_W'(270)) begin
            i     = r - ANG_W'(180);
            f.neg = 1'b1;
        end else begin
            i     = ANG_W'(360) - r;
            f.neg = 1'b1;
        end
        f.idx = i[6:0];
        return f;
    endfunction

endpackage
`default_nettype wire

/* hdl/nds_dir_gen.sv */
`default_nettype none
module nds_dir_gen (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_go,
    input  wire logic [6:0]            i_polar_deg,
    input  wire logic [8:0]            i_azimuth_deg,
    output logic                       o_vec_valid,
    output nds_pkg::t_dir_vec          o_vec
);
    import nds_pkg::*;

    t_fold f_sp, f_cp, f_sa, f_ca;

    logic             r_s1;
    logic             r_s2;
    logic [SIN_W-1:0] r_sp_m, r_cp_m, r_sa_m, r_ca_m;
    logic             r_sp_n, r_cp_n, r_sa_n, r_ca_n;
    t_dir_vec         r_vec;

    logic [2*SIN_W-1:0] p_x, p_y;
    logic [SIN_W-1:0]   m_x, m_y;

    // fold the four angles, then look up the magnitudes
    always_comb begin
        f_sp = fold_angle(ANG_W'(i_polar_deg));
        f_cp = fold_angle(ANG_W'(i_polar_deg) + ANG_W'(90));
        f_sa = fold_angle(ANG_W'(i_azimuth_deg));
        f_ca = fold_angle(ANG_W'(i_azimuth_deg) + ANG_W'(90));
    end

    // round half up on magnitudes, sign applied afterwards
    assign p_x = (2*SIN_W)'(r_ca_m) * (2*SIN_W)'(r_sp_m)
               + ((2*SIN_W)'(1) << (COORD_FRAC_BITS - 1));
    assign p_y = (2*SIN_W)'(r_sa_m) * (2*SIN_W)'(r_sp_m)
               + ((2*SIN_W)'(1) << (COORD_FRAC_BITS - 1));
    assign m_x = p_x[COORD_FRAC_BITS +: SIN_W];
    assign m_y = p_y[COORD_FRAC_BITS +: SIN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
            r_s2 <= 1'b0;
        end else begin
            r_s1 <= i_go;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_sp_m <= SIN_TAB[f_sp.idx];
            r_cp_m <= SIN_TAB[f_cp.idx];
            r_sa_m <= SIN_TAB[f_sa.idx];
            r_ca_m <= SIN_TAB[f_ca.idx];
            r_sp_n <= f_sp.neg;
            r_cp_n <= f_cp.neg;
            r_sa_n <= f_sa.neg;
            r_ca_n <= f_ca.neg;
        end
        if (r_s1) begin
            r_vec.x <= (r_ca_n ^ r_sp_n) ? -$signed(COORD_W'(m_x)) : $signed(COORD_W'(m_x));
            r_vec.y <= (r_sa_n ^ r_sp_n) ? -$signed(COORD_W'(m_y)) : $signed(COORD_W'(m_y));
            r_vec.z <= r_cp_n ? -$signed(COORD_W'(r_cp_m)) : $signed(COORD_W'(r_cp_m));
        end
    end

    assign o_vec_valid = r_s2;
    assign o_vec       = r_vec;

endmodule
`default_nettype wire

/* hdl/nearest_dome_direction_search_core.sv */
`default_nettype none
// Nearest dome direction search. A load item (mode 0) writes one dome point into a
// 1024-entry store; it gives no result. A query item (mode 1) turns its
// polar/azimuth degrees into a Q1.14 direction vector, then scans entries 0..N-1,
// N = min(points_in_use, 1024), at one store read per cycle, and after a 4-stage
// read/square/sum/compare pipeline strobes o_done for one cycle with the nearest
// index (first minimum wins) and the squared distance, saturated to 32 bits. When N
// is 0, found is 0 and index and distance are 0. The single store read port sets the
// one-point-per-cycle scan. busy is high from a query's accept until its o_done cycle,
// and start is taken again in that cycle. The receiver cannot stall: capture the
// result when o_done is high. Write points_in_use only while idle.
module nearest_dome_direction_search_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_mode,
    input  wire logic [nds_pkg::ADDR_W-1:0]   i_point_index,
    input  wire logic signed [15:0]           i_point_x,
    input  wire logic signed [15:0]           i_point_y,
    input  wire logic signed [15:0]           i_point_z,
    input  wire logic [6:0]                   i_polar_deg,
    input  wire logic [8:0]                   i_azimuth_deg,
    // result
    output logic                              o_done,
    output logic [nds_pkg::ADDR_W-1:0]        o_nearest_index,
    output logic                              o_found,
    output logic [31:0]                       o_min_distance_sq,
    // config
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import nds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIR   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // dome store: {x, y, z}
    logic [3*COORD_W-1:0] mem [0:DOME_POINTS-1];
    logic [3*COORD_W-1:0] r_rd_data;

    logic               accept, go, load;
    logic               vec_valid;
    t_dir_vec           vec;

    logic [COUNT_W-1:0] r_points;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] count_sat;
    logic [ADDR_W-1:0]  r_addr;
    logic               issue, last;

    // pipeline: read data -> squares -> sum -> compare
    logic               r_v1, r_v2, r_v3;
    logic               r_l1, r_l2, r_l3;
    logic [ADDR_W-1:0]  r_i1, r_i2, r_i3;
    logic [SQ_W-1:0]    r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]  r_dist;

    logic               r_bfound;
    logic [ADDR_W-1:0]  r_bidx;
    logic [DIST_W-1:0]  r_bdist;
    logic               better;
    logic [ADDR_W-1:0]  sel_idx;
    logic [DIST_W-1:0]  sel_dist;

    logic signed [DIFF_W-1:0]   dx, dy, dz;
    logic signed [2*DIFF_W-1:0] px, py, pz;

    logic               r_done;
    logic [ADDR_W-1:0]  r_out_idx;
    logic               r_out_found;
    logic [31:0]        r_out_dist;

    logic               cfg_wr;

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;
    assign go     = accept & i_mode;
    assign load   = accept & ~i_mode;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_POINTS_IN_USE) ? 32'(r_points) : 32'd0;

    assign count_sat = (r_points > COUNT_W'(DOME_POINTS)) ? COUNT_W'(DOME_POINTS) : r_points;
    assign issue     = (r_state == S_SCAN);
    assign last      = ({1'b0, r_addr} == r_count - COUNT_W'(1));

    nds_dir_gen u_dir (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_polar_deg   (i_polar_deg),
        .i_azimuth_deg (i_azimuth_deg),
        .o_vec_valid   (vec_valid),
        .o_vec         (vec)
    );

    // loads are only taken while idle and the scan only runs while busy,
    // so a scan read never meets a write to the same entry; other reads go unused
    always_ff @(posedge i_clk) begin
        if (load) begin
            mem[i_point_index] <= {i_point_x, i_point_y, i_point_z};
        end
        r_rd_data <= mem[r_addr];
    end

    // distance datapath
    always_comb begin
        dx = DIFF_W'(vec.x) - DIFF_W'($signed(r_rd_data[3*COORD_W-1:2*COORD_W]));
        dy = DIFF_W'(vec.y) - DIFF_W'($signed(r_rd_data[2*COORD_W-1:COORD_W]));
        dz = DIFF_W'(vec.z) - DIFF_W'($signed(r_rd_data[COORD_W-1:0]));
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    // strict less-than keeps the first minimum
    assign better   = ~r_bfound | (r_dist < r_bdist);
    assign sel_idx  = better ? r_i3 : r_bidx;
    assign sel_dist = better ? r_dist : r_bdist;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (go) n_state = S_DIR;
            S_DIR: begin
                if (vec_valid) begin
                    n_state = (count_sat == '0) ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN:  if (last) n_state = S_DRAIN;
            S_DRAIN: if (r_v3 & r_l3) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_points <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_bfound <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr[2] == REG_POINTS_IN_USE) begin
                r_points <= pwdata[COUNT_W-1:0];
            end
            r_v1   <= issue;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= 1'b0;
            if (r_state == S_DIR && vec_valid) begin
                r_bfound <= 1'b0;
                if (count_sat == '0) begin
                    r_done <= 1'b1;
                end
            end else if (r_v3) begin
                r_bfound <= 1'b1;
                if (r_l3) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIR && vec_valid) begin
            r_count     <= count_sat;
            r_addr      <= '0;
            r_out_idx   <= '0;
            r_out_found <= 1'b0;
            r_out_dist  <= '0;
        end else if (issue) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        r_l1  <= last;
        r_i1  <= r_addr;
        r_l2  <= r_l1;
        r_i2  <= r_i1;
        r_sqx <= px[SQ_W-1:0];
        r_sqy <= py[SQ_W-1:0];
        r_sqz <= pz[SQ_W-1:0];
        r_l3  <= r_l2;
        r_i3  <= r_i2;
        r_dist <= DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);
        if (r_v3) begin
            r_bidx  <= sel_idx;
            r_bdist <= sel_dist;
            if (r_l3) begin
                r_out_idx   <= sel_idx;
                r_out_found <= 1'b1;
                r_out_dist  <= (|sel_dist[DIST_W-1:32]) ? 32'hFFFF_FFFF : sel_dist[31:0];
            end
        end
    end

    assign o_done            = r_done;
    assign o_nearest_index   = r_out_idx;
    assign o_found           = r_out_found;
    assign o_min_distance_sq = r_out_dist;

endmodule
`default_nettype wire
